// ===== src/ace_pkg.sv =====
// Shared types, widths, codes and reset values for the cadence estimator.
package ace_pkg;

  localparam int MaxSamplesDef = 512;
  localparam int SampleBitsDef = 16;
  localparam int LanesDef      = 8;

  localparam int LagW  = 9;
  localparam int RateW = 17;
  localparam int CadW  = 23;
  localparam int StatW = 2;

  localparam logic [LagW-1:0]  MinLagRst = LagW'(15);
  localparam logic [LagW-1:0]  MaxLagRst = LagW'(160);
  localparam logic [RateW-1:0] RateRst   = RateW'(5000);
  localparam logic [5:0]       SecPerMin = 6'd60;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_NO_LAG   = 2'd1;
  localparam logic [StatW-1:0] ST_OVERFLOW = 2'd2;

  localparam logic [1:0] REG_MIN_LAG = 2'd0;
  localparam logic [1:0] REG_MAX_LAG = 2'd1;
  localparam logic [1:0] REG_RATE    = 2'd2;

  typedef struct packed {
    logic clr;    // zero the score accumulator
    logic shift;  // take the lagged value from the right neighbor
    logic tap;    // broadcast value is a real series element
  } ace_ctl_t;

endpackage

// ===== src/ace_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module ace_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== src/ace_cell.sv =====
// One correlation cell: holds a lagged value, multiplies and accumulates.
module ace_cell
  import ace_pkg::*;
#(
  parameter int CW    = 27,
  parameter int ACCW  = 64,
  parameter int SW    = 14,
  parameter int LGW   = 10,
  parameter int SMW   = 15
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ace_ctl_t               ctl_i,
  input  logic signed [CW-1:0]   a_i,
  input  logic signed [CW-1:0]   b_i,
  input  logic [SW-1:0]          s_i,
  input  logic [LGW-1:0]         lag_i,
  input  logic [SMW-1:0]         lim_i,
  output logic signed [CW-1:0]   b_o,
  output logic signed [ACCW-1:0] acc_o
);

  logic signed [CW-1:0]   b_q;
  logic signed [2*CW-1:0] prod_q;
  logic                   en_q;
  logic signed [ACCW-1:0] acc_q;
  logic [SMW-1:0]         reach;

  // Term counts only while the lagged index stays inside the series.
  assign reach = SMW'(s_i) + SMW'(lag_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      en_q <= ctl_i.tap && (reach < lim_i);
      if (ctl_i.clr) begin
        acc_q <= '0;
      end else if (en_q) begin
        acc_q <= acc_q + ACCW'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      b_q <= b_i;
    end
    prod_q <= a_i * b_q;
  end

  assign b_o   = b_q;
  assign acc_o = acc_q;

endmodule

// ===== src/ace_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ace_div
  import ace_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CadW-1:0]  dividend_i,
  input  logic [LagW-1:0]  divisor_i,
  output logic             done_o,
  output logic [CadW-1:0]  quot_o
);

  localparam int CntW = $clog2(CadW + 1);

  logic [LagW:0]     rem_q, rem_sh, rem_sub;
  logic [CadW-1:0]   quo_q;
  logic [LagW-1:0]   dsr_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q, fits;

  assign rem_sh  = {rem_q[LagW-1:0], quo_q[CadW-1]};
  assign fits    = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CntW'(CadW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dsr_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= fits ? rem_sub : rem_sh;
        quo_q <= {quo_q[CadW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(CadW - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== src/autocorrelation_cadence_estimator.sv =====
// Flow: samples load one per cycle while in the load state; after the last sample an eval step,
// then per group of LANES lags a stream pass, a drain and a scan of the cells, then the divider
// and the output register. Overflow or an empty lag range goes from eval to the output register.
// Throughput: one series at a time; the lane chain and the sample RAM read ports set the pace.
// Reset: registers go to min_lag 15, max_lag 160, rate 5000; series empty; store not cleared.
module autocorrelation_cadence_estimator
  import ace_pkg::*;
#(
  parameter int MAX_SAMPLES = MaxSamplesDef,  // 2..4096
  parameter int SAMPLE_BITS = SampleBitsDef,  // 8..24
  parameter int LANES       = LanesDef        // 2..256 cells in the chain
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          last_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [StatW-1:0]              status_o,
  output logic [LagW-1:0]               peak_lag_o,
  output logic [CadW-1:0]               cadence_centi_spm_o,
  output logic                          confidence_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int SUMW = SAMPLE_BITS + CNTW;
  localparam int CW   = SUMW + 1;                 // centered value n*x - S
  localparam int ACCW = 2 * CW + CNTW;            // exact lag score
  localparam int KW   = $clog2(LANES);
  localparam int SW   = CNTW + KW + 1;            // stream step counter
  localparam int LGW  = LagW + 1;                 // lag group base and cell lags
  localparam int SMW  = ((SW > LGW) ? SW : LGW) + 1;
  localparam int CMPW = (CNTW > LagW) ? CNTW : LagW;

  typedef enum logic [2:0] {
    S_LOAD, S_EVAL, S_RUN, S_DRAIN, S_SCAN, S_DIVST, S_DIVW, S_DONE
  } state_e;

  // Registers
  logic [LagW-1:0]  min_lag_q, max_lag_q;
  logic [RateW-1:0] rate_q;

  state_e                  state_q;
  logic [CNTW-1:0]         count_q;
  logic signed [SUMW-1:0]  sum_q;
  logic                    ovf_q;
  logic [LagW-1:0]         hi_q;
  logic [LGW-1:0]          base_q;
  logic [SW-1:0]           s_q;
  logic [1:0]              drain_q;
  logic [KW-1:0]           scan_q;
  logic signed [ACCW-1:0]  best_q;
  logic [LagW-1:0]         peak_lag_q;
  logic                    tag1_vld_q, tag2_vld_q;
  logic [SW-1:0]           tag1_s_q, tag2_s_q;
  logic signed [CW-1:0]    a_q;
  logic                    clr_q;
  logic [StatW-1:0]        res_status_q;
  logic [LagW-1:0]         res_lag_q;
  logic [CadW-1:0]         res_cad_q;
  logic                    res_conf_q;
  logic                    out_valid_q;
  logic [StatW-1:0]        status_q;
  logic [LagW-1:0]         out_lag_q;
  logic [CadW-1:0]         out_cad_q;
  logic                    conf_q;

  // ---------------------------------------------------------------------------
  // Register port: writes land on the access cycle, reads are combinational.
  // ---------------------------------------------------------------------------
  logic cfg_we;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_MIN_LAG: prdata = 32'(min_lag_q);
      REG_MAX_LAG: prdata = 32'(max_lag_q);
      REG_RATE:    prdata = 32'(rate_q);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_lag_q <= MinLagRst;
      max_lag_q <= MaxLagRst;
      rate_q    <= RateRst;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_MIN_LAG: min_lag_q <= pwdata[LagW-1:0];
        REG_MAX_LAG: max_lag_q <= pwdata[LagW-1:0];
        REG_RATE:    rate_q    <= pwdata[RateW-1:0];
        default:     ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Load: one request per cycle into the sample store while in the load state.
  // ---------------------------------------------------------------------------
  logic in_acc, room;
  assign in_ready_o = (state_q == S_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign room       = count_q < CNTW'(MAX_SAMPLES);

  // Lag range: raise min_lag to one, clip max_lag to n - 1.
  logic [CMPW-1:0] n_ext, nm1_ext, max_ext;
  logic [LagW-1:0] lo_c, hi_c;
  assign n_ext   = CMPW'(count_q);
  assign nm1_ext = n_ext - 1'b1;
  assign max_ext = CMPW'(max_lag_q);
  assign lo_c    = (min_lag_q == '0) ? LagW'(1) : min_lag_q;
  assign hi_c    = (max_ext >= n_ext) ? nm1_ext[LagW-1:0] : max_lag_q;

  // ---------------------------------------------------------------------------
  // Stream: port A broadcasts c[i], port B feeds the chain at the far end so
  // cell k meets c[i + base + k] while c[i] passes.
  // ---------------------------------------------------------------------------
  logic [SMW-1:0]          lim;      // n + LANES - 1
  logic [SMW-1:0]          addr_a_w, addr_b_w;
  logic [AW-1:0]           raddr_a, raddr_b;
  logic [SAMPLE_BITS-1:0]  rd_a, rd_b;
  logic signed [CW-1:0]    nx_a, nx_b, ca, cb, sum_ext;
  logic                    issue, run_end;

  assign lim      = SMW'(count_q) + SMW'(LANES - 1);
  assign addr_a_w = SMW'(s_q) - SMW'(LANES - 1);
  assign addr_b_w = SMW'(s_q) + SMW'(base_q);
  assign raddr_a  = addr_a_w[AW-1:0];
  assign raddr_b  = addr_b_w[AW-1:0];
  assign issue    = (state_q == S_RUN);
  assign run_end  = (SMW'(s_q) + SMW'(1)) == lim;

  ace_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (in_acc && room),
    .waddr_i   (count_q[AW-1:0]),
    .wdata_i   (sample_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign sum_ext = CW'(sum_q);
  assign nx_a    = $signed({1'b0, count_q}) * $signed(rd_a);
  assign nx_b    = $signed({1'b0, count_q}) * $signed(rd_b);
  assign ca      = nx_a - sum_ext;
  assign cb      = nx_b - sum_ext;

  // Chain of cells
  ace_ctl_t              ctl;
  logic signed [CW-1:0]  chain_b [LANES];
  logic signed [ACCW-1:0] acc [LANES];

  assign ctl.clr   = clr_q;
  assign ctl.shift = tag1_vld_q;
  assign ctl.tap   = tag2_vld_q && (tag2_s_q >= SW'(LANES - 1));

  for (genvar k = 0; k < LANES; k++) begin : g_cell
    logic signed [CW-1:0] b_in;
    if (k == LANES - 1) begin : g_end
      assign b_in = cb;
    end else begin : g_mid
      assign b_in = chain_b[k+1];
    end
    ace_cell #(
      .CW   (CW),
      .ACCW (ACCW),
      .SW   (SW),
      .LGW  (LGW),
      .SMW  (SMW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .a_i    (a_q),
      .b_i    (b_in),
      .s_i    (tag2_s_q),
      .lag_i  (base_q + LGW'(k)),
      .lim_i  (lim),
      .b_o    (chain_b[k]),
      .acc_o  (acc[k])
    );
  end

  // Scan: walk the cells in lag order, keep the strictly largest score.
  logic signed [ACCW-1:0] acc_sel;
  logic [LGW-1:0]         scan_lag, base_nx;
  logic                   take;
  assign acc_sel  = acc[scan_q];
  assign scan_lag = base_q + LGW'(scan_q);
  assign base_nx  = base_q + LGW'(LANES);
  assign take     = (scan_lag <= LGW'(hi_q)) && (acc_sel > best_q);

  // Clear the accumulators on the way into each lag group.
  logic clr_d;
  assign clr_d = ((state_q == S_EVAL) && !ovf_q && !(hi_c < lo_c)) ||
                 ((state_q == S_SCAN) && (scan_q == KW'(LANES - 1)) &&
                  !(base_nx > LGW'(hi_q)));

  // Divider: 60 * rate / lag
  logic [CadW-1:0] dividend, quot;
  logic            div_done;
  assign dividend = CadW'(rate_q) * CadW'(SecPerMin);

  ace_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIVST),
    .dividend_i (dividend),
    .divisor_i  (peak_lag_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  logic [2*CNTW-1:0] nsq;
  assign nsq = count_q * count_q;

  always_ff @(posedge clk_i) begin
    if (tag1_vld_q) begin
      a_q <= ca;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      count_q      <= '0;
      sum_q        <= '0;
      ovf_q        <= 1'b0;
      hi_q         <= '0;
      base_q       <= '0;
      s_q          <= '0;
      drain_q      <= '0;
      scan_q       <= '0;
      best_q       <= '0;
      peak_lag_q   <= '0;
      tag1_vld_q   <= 1'b0;
      tag2_vld_q   <= 1'b0;
      tag1_s_q     <= '0;
      tag2_s_q     <= '0;
      clr_q        <= 1'b0;
      res_status_q <= ST_OK;
      res_lag_q    <= '0;
      res_cad_q    <= '0;
      res_conf_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      out_lag_q    <= '0;
      out_cad_q    <= '0;
      conf_q       <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      tag1_vld_q <= issue;
      tag1_s_q   <= s_q;
      tag2_vld_q <= tag1_vld_q;
      tag2_s_q   <= tag1_s_q;
      // the output register is reloaded in S_DONE, so only drop it elsewhere
      if (out_valid_q && out_ready_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (room) begin
              count_q <= count_q + 1'b1;
              sum_q   <= sum_q + SUMW'(sample_i);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_i) begin
              state_q <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          res_lag_q    <= '0;
          res_cad_q    <= '0;
          res_conf_q   <= 1'b0;
          hi_q         <= hi_c;
          base_q       <= LGW'(lo_c);
          peak_lag_q   <= lo_c;
          best_q       <= -$signed(ACCW'(nsq));
          s_q          <= '0;
          if (ovf_q) begin
            res_status_q <= ST_OVERFLOW;
            state_q      <= S_DONE;
          end else if (hi_c < lo_c) begin
            res_status_q <= ST_NO_LAG;
            state_q      <= S_DONE;
          end else begin
            res_status_q <= ST_OK;
            state_q      <= S_RUN;
          end
        end
        S_RUN: begin
          s_q <= s_q + 1'b1;
          if (run_end) begin
            drain_q <= '0;
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // hold until the last product lands in the accumulators
          drain_q <= drain_q + 1'b1;
          if (drain_q == 2'd3) begin
            scan_q  <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (take) begin
            best_q     <= acc_sel;
            peak_lag_q <= scan_lag[LagW-1:0];
          end
          scan_q <= scan_q + 1'b1;
          if (scan_q == KW'(LANES - 1)) begin
            if (base_nx > LGW'(hi_q)) begin
              state_q <= S_DIVST;
            end else begin
              base_q  <= base_nx;
              s_q     <= '0;
              state_q <= S_RUN;
            end
          end
        end
        S_DIVST: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            res_lag_q  <= peak_lag_q;
            res_cad_q  <= quot;
            res_conf_q <= 1'b1;
            state_q    <= S_DONE;
          end
        end
        S_DONE: begin
          // drop the series once the result is in the output register
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            out_lag_q   <= res_lag_q;
            out_cad_q   <= res_cad_q;
            conf_q      <= res_conf_q;
            count_q     <= '0;
            sum_q       <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign peak_lag_o          = out_lag_q;
  assign cadence_centi_spm_o = out_cad_q;
  assign confidence_o        = conf_q;

endmodule
